/* sv/psn_pkg.sv */
// Package for the polyline smooth normals block.
// Holds shared widths, the job descriptor and the bank release struct.
// Used by every module of the block; depends on nothing.
package psn_pkg;
	localparam int unsigned MAX_POINTS_DEF = 64;
	localparam int unsigned PT_W = 7;
	localparam int unsigned SUM_W = 38;
	localparam int unsigned VW = 41;
	localparam int unsigned NW = 16;

	typedef struct packed {
		logic [PT_W-1:0]         n;
		logic                    closed;
		logic                    bank;
		logic signed [SUM_W-1:0] sum_x;
		logic signed [SUM_W-1:0] sum_y;
	} job_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;
endpackage

/* sv/psn_unit.sv */
// Iterative vector normalizer producing a Q1.14 unit vector.
// Shift normalization, squares, 32-step square root, 16-step divide.
// Depends on psn_pkg.
module psn_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [psn_pkg::VW-1:0] a,
	input  logic signed [psn_pkg::VW-1:0] b,
	output logic                         done,
	output logic signed [psn_pkg::NW-1:0] ox,
	output logic signed [psn_pkg::NW-1:0] oy
);
	import psn_pkg::*;

	typedef enum logic [2:0] {U_IDLE, U_NORM, U_SQ, U_SUM, U_SQRT, U_DSET, U_DIV} ust_t;

	ust_t              st_q;
	logic              na_q, nb_q;
	logic [VW-1:0]     ua_q, ub_q, m;
	logic [59:0]       sqa_q, sqb_q, sqa, sqb;
	logic [63:0]       v_q, r_q, bit_q, rb_sum;
	logic [47:0]       ds_q, ra_q, rb_q;
	logic [15:0]       qa_q, qb_q, qa_n, qb_n;
	logic [3:0]        k_q;
	logic              done_q;
	logic signed [NW-1:0] ox_q, oy_q;

	assign m = (ua_q > ub_q) ? ua_q : ub_q;
	assign sqa = ua_q[29:0] * ua_q[29:0];
	assign sqb = ub_q[29:0] * ub_q[29:0];
	assign rb_sum = r_q + bit_q;
	assign qa_n = {qa_q[14:0], ra_q >= ds_q};
	assign qb_n = {qb_q[14:0], rb_q >= ds_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= U_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				U_IDLE: begin
					if (start) begin
						na_q <= a[VW-1];
						nb_q <= b[VW-1];
						ua_q <= a[VW-1] ? VW'(-a) : VW'(a);
						ub_q <= b[VW-1] ? VW'(-b) : VW'(b);
						if (a == '0 && b == '0) begin
							ox_q <= '0;
							oy_q <= '0;
							done_q <= 1'b1;
						end else begin
							st_q <= U_NORM;
						end
					end
				end
				U_NORM: begin
					if (|m[VW-1:30]) begin
						ua_q <= ua_q >> 1;
						ub_q <= ub_q >> 1;
					end else if (!m[29]) begin
						ua_q <= ua_q << 1;
						ub_q <= ub_q << 1;
					end else begin
						st_q <= U_SQ;
					end
				end
				U_SQ: begin
					sqa_q <= sqa;
					sqb_q <= sqb;
					st_q <= U_SUM;
				end
				U_SUM: begin
					v_q <= 64'(sqa_q) + 64'(sqb_q);
					r_q <= '0;
					bit_q <= 64'(1) << 62;
					st_q <= U_SQRT;
				end
				U_SQRT: begin
					if (v_q >= rb_sum) begin
						v_q <= v_q - rb_sum;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) st_q <= U_DSET;
				end
				U_DSET: begin
					ds_q <= {r_q[31:0], 16'b0};
					ra_q <= 48'({ua_q[29:0], 15'b0}) + 48'(r_q[31:0]);
					rb_q <= 48'({ub_q[29:0], 15'b0}) + 48'(r_q[31:0]);
					qa_q <= '0;
					qb_q <= '0;
					k_q <= 4'd15;
					st_q <= U_DIV;
				end
				U_DIV: begin
					if (ra_q >= ds_q) ra_q <= ra_q - ds_q;
					if (rb_q >= ds_q) rb_q <= rb_q - ds_q;
					qa_q <= qa_n;
					qb_q <= qb_n;
					ds_q <= ds_q >> 1;
					k_q <= k_q - 4'd1;
					if (k_q == 4'd0) begin
						ox_q <= na_q ? -$signed(qa_n) : $signed(qa_n);
						oy_q <= nb_q ? -$signed(qb_n) : $signed(qb_n);
						done_q <= 1'b1;
						st_q <= U_IDLE;
					end
				end
				default: st_q <= U_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign ox = ox_q;
	assign oy = oy_q;
endmodule

/* sv/psn_front.sv */
// Front end: takes point beats, stores them in a two-bank point memory,
// keeps the count and coordinate sums, and posts one job per profile.
// Depends on psn_pkg.
module psn_front #(
	parameter int unsigned MAX_POINTS = psn_pkg::MAX_POINTS_DEF,
	localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  point_x,
	input  logic signed [31:0]  point_y,
	input  logic                last_point,
	output logic                job_push,
	output psn_pkg::job_t       job,
	input  psn_pkg::rel_t       rel,
	input  logic [IW:0]         rd_addr,
	output logic signed [31:0]  rd_x,
	output logic signed [31:0]  rd_y
);
	import psn_pkg::*;

	localparam int unsigned DEPTH = 2 ** (IW + 1);

	logic signed [31:0]      xmem [DEPTH];
	logic signed [31:0]      ymem [DEPTH];
	logic signed [31:0]      rd_x_q, rd_y_q;
	logic                    wbank_q, closed_q;
	logic [1:0]              busy_q;
	logic [PT_W-1:0]         cnt_q, cnt_n;
	logic signed [SUM_W-1:0] sumx_q, sumy_q, sumx_n, sumy_n;
	logic                    acc, room;

	assign in_ready = !busy_q[wbank_q];
	assign acc = in_valid && in_ready;
	assign room = cnt_q < PT_W'(MAX_POINTS);
	assign cnt_n = room ? cnt_q + PT_W'(1) : cnt_q;
	assign sumx_n = room ? sumx_q + SUM_W'(point_x) : sumx_q;
	assign sumy_n = room ? sumy_q + SUM_W'(point_y) : sumy_q;

	assign job_push = acc && last_point;
	assign job.n = cnt_n;
	assign job.closed = closed_q;
	assign job.bank = wbank_q;
	assign job.sum_x = sumx_n;
	assign job.sum_y = sumy_n;

	always_ff @(posedge clk) begin
		if (acc && room) begin
			xmem[{wbank_q, cnt_q[IW-1:0]}] <= point_x;
			ymem[{wbank_q, cnt_q[IW-1:0]}] <= point_y;
		end
		rd_x_q <= xmem[rd_addr];
		rd_y_q <= ymem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wbank_q <= 1'b0;
			closed_q <= 1'b1;
			busy_q <= '0;
			cnt_q <= '0;
			sumx_q <= '0;
			sumy_q <= '0;
		end else begin
			if (cfg_wr_en) closed_q <= cfg_wr_data;
			if (rel.valid) busy_q[rel.bank] <= 1'b0;
			if (acc) begin
				if (last_point) begin
					busy_q[wbank_q] <= 1'b1;
					wbank_q <= !wbank_q;
					cnt_q <= '0;
					sumx_q <= '0;
					sumy_q <= '0;
				end else begin
					cnt_q <= cnt_n;
					sumx_q <= sumx_n;
					sumy_q <= sumy_n;
				end
			end
		end
	end

	assign rd_x = rd_x_q;
	assign rd_y = rd_y_q;
endmodule

/* sv/psn_jobq.sv */
// Two-entry job queue between the front end and the normal sequencer.
// Depends on psn_pkg.
module psn_jobq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  psn_pkg::job_t din,
	input  logic          pop,
	output logic          avail,
	output psn_pkg::job_t dout
);
	import psn_pkg::*;

	job_t       q_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign avail = cnt_q != 2'd0;
	assign do_pop = pop && avail;
	assign do_push = push && (cnt_q != 2'd2);
	assign dout = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) q_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end
endmodule

/* sv/psn_back.sv */
// Back end: walks the stored points of one job, sums the unit edge normals,
// falls back to the radial direction, orients and emits each normal beat.
// Depends on psn_pkg and psn_unit.
module psn_back #(
	parameter int unsigned MAX_POINTS = psn_pkg::MAX_POINTS_DEF,
	localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_avail,
	input  psn_pkg::job_t                 job,
	output logic                          job_pop,
	output logic [IW:0]                   rd_addr,
	input  logic signed [31:0]            rd_x,
	input  logic signed [31:0]            rd_y,
	output psn_pkg::rel_t                 rel,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [psn_pkg::NW-1:0] normal_x,
	output logic signed [psn_pkg::NW-1:0] normal_y,
	output logic                          last_normal
);
	import psn_pkg::*;

	typedef enum logic [3:0] {
		B_IDLE, B_RD0, B_RD1, B_RD2, B_RD3, B_E1, B_W1, B_E2, B_W2,
		B_RAD, B_N, B_WN, B_DOT, B_SGN, B_OUT
	} bst_t;

	bst_t               st_q;
	job_t               job_q;
	logic [PT_W-1:0]    i_q, prev, next;
	logic signed [31:0] cx_q, cy_q, px_q, py_q, nx_q, ny_q;
	logic signed [17:0] sx_q, sy_q;
	logic signed [VW-1:0] rx_q, ry_q, dx, dy, rx_n, ry_n;
	logic signed [NW-1:0] vx_q, vy_q;
	logic signed [VW+15:0] dpx_q, dpy_q;
	logic signed [VW+16:0] dot;
	logic               u_start_q, u_done, is_last, has_prev, has_next, pop_q;
	logic signed [VW-1:0] u_a_q, u_b_q;
	logic signed [NW-1:0] u_ox, u_oy;
	logic               ov_q, ol_q;
	logic signed [NW-1:0] ox_q, oy_q;
	rel_t               rel_q;

	assign is_last = (i_q + PT_W'(1)) == job_q.n;
	assign prev = (i_q == '0) ? job_q.n - PT_W'(1) : i_q - PT_W'(1);
	assign next = is_last ? '0 : i_q + PT_W'(1);
	assign has_prev = job_q.closed || (i_q != '0);
	assign has_next = job_q.closed || !is_last;
	assign rx_n = VW'($signed({1'b0, job_q.n})) * VW'(cx_q) - VW'(job_q.sum_x);
	assign ry_n = VW'($signed({1'b0, job_q.n})) * VW'(cy_q) - VW'(job_q.sum_y);
	assign dot = (VW+17)'(dpx_q) + (VW+17)'(dpy_q);

	always_comb begin
		dx = '0;
		dy = '0;
		if (st_q == B_E1) begin
			dx = VW'(cx_q) - VW'(px_q);
			dy = VW'(cy_q) - VW'(py_q);
		end else begin
			dx = VW'(nx_q) - VW'(cx_q);
			dy = VW'(ny_q) - VW'(cy_q);
		end
	end

	always_comb begin
		case (st_q)
			B_RD1:   rd_addr = {job_q.bank, prev[IW-1:0]};
			B_RD2:   rd_addr = {job_q.bank, next[IW-1:0]};
			default: rd_addr = {job_q.bank, i_q[IW-1:0]};
		endcase
	end

	psn_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (u_start_q),
		.a      (u_a_q),
		.b      (u_b_q),
		.done   (u_done),
		.ox     (u_ox),
		.oy     (u_oy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			u_start_q <= 1'b0;
			pop_q <= 1'b0;
			ov_q <= 1'b0;
			rel_q <= '0;
		end else begin
			u_start_q <= 1'b0;
			pop_q <= 1'b0;
			rel_q.valid <= 1'b0;
			case (st_q)
				B_IDLE: begin
					if (job_avail && !pop_q) begin
						job_q <= job;
						pop_q <= 1'b1;
						i_q <= '0;
						st_q <= B_RD0;
					end
				end
				B_RD0: begin
					sx_q <= '0;
					sy_q <= '0;
					st_q <= B_RD1;
				end
				B_RD1: begin
					cx_q <= rd_x;
					cy_q <= rd_y;
					st_q <= B_RD2;
				end
				B_RD2: begin
					px_q <= rd_x;
					py_q <= rd_y;
					st_q <= B_RD3;
				end
				B_RD3: begin
					nx_q <= rd_x;
					ny_q <= rd_y;
					st_q <= B_E1;
				end
				B_E1: begin
					if (has_prev && (dx != '0 || dy != '0)) begin
						u_a_q <= dy;
						u_b_q <= -dx;
						u_start_q <= 1'b1;
						st_q <= B_W1;
					end else begin
						st_q <= B_E2;
					end
				end
				B_W1: begin
					if (u_done) begin
						sx_q <= sx_q + 18'(u_ox);
						sy_q <= sy_q + 18'(u_oy);
						st_q <= B_E2;
					end
				end
				B_E2: begin
					if (has_next && (dx != '0 || dy != '0)) begin
						u_a_q <= dy;
						u_b_q <= -dx;
						u_start_q <= 1'b1;
						st_q <= B_W2;
					end else begin
						st_q <= B_RAD;
					end
				end
				B_W2: begin
					if (u_done) begin
						sx_q <= sx_q + 18'(u_ox);
						sy_q <= sy_q + 18'(u_oy);
						st_q <= B_RAD;
					end
				end
				B_RAD: begin
					rx_q <= rx_n;
					ry_q <= ry_n;
					st_q <= B_N;
				end
				B_N: begin
					if (sx_q != '0 || sy_q != '0) begin
						u_a_q <= VW'(sx_q);
						u_b_q <= VW'(sy_q);
						u_start_q <= 1'b1;
						st_q <= B_WN;
					end else if (rx_q != '0 || ry_q != '0) begin
						u_a_q <= rx_q;
						u_b_q <= ry_q;
						u_start_q <= 1'b1;
						st_q <= B_WN;
					end else begin
						vx_q <= NW'(16384);
						vy_q <= '0;
						st_q <= B_DOT;
					end
				end
				B_WN: begin
					if (u_done) begin
						vx_q <= u_ox;
						vy_q <= u_oy;
						st_q <= B_DOT;
					end
				end
				B_DOT: begin
					dpx_q <= vx_q * rx_q;
					dpy_q <= vy_q * ry_q;
					st_q <= B_SGN;
				end
				B_SGN: begin
					ox_q <= dot[VW+16] ? -vx_q : vx_q;
					oy_q <= dot[VW+16] ? -vy_q : vy_q;
					ol_q <= is_last;
					ov_q <= 1'b1;
					st_q <= B_OUT;
				end
				B_OUT: begin
					if (out_ready) begin
						ov_q <= 1'b0;
						if (is_last) begin
							rel_q.valid <= 1'b1;
							rel_q.bank <= job_q.bank;
							st_q <= B_IDLE;
						end else begin
							i_q <= i_q + PT_W'(1);
							st_q <= B_RD0;
						end
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	assign job_pop = pop_q;
	assign rel = rel_q;
	assign out_valid = ov_q;
	assign normal_x = ox_q;
	assign normal_y = oy_q;
	assign last_normal = ol_q;
endmodule

/* sv/polyline_smooth_normals_top.sv */
// Top level of the polyline smooth normals block.
// Connects the front end, the job queue and the normal sequencer.
// Depends on psn_pkg, psn_front, psn_jobq and psn_back.
//
// Channel  Direction  Handshake              Payload
// point    in         in_valid / in_ready    point_x, point_y, last_point
// normal   out        out_valid / out_ready  normal_x, normal_y, last_normal
// config   in         cfg_wr_en              cfg_wr_data (closed_loop)
//
// Points are taken at one beat per cycle while the write bank is free.
// Each normal uses the shared normalize unit (shift alignment, a 32-step square
// root and a 16-step divide) up to three times per point; output stalls hold
// the sequencer until out_ready. Two point banks let the next profile load
// while one is processed.
// Reset clears counts, sums, queue and sequencer but not the banks.
module polyline_smooth_normals_top #(
	parameter int unsigned MAX_POINTS = psn_pkg::MAX_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic                          cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [31:0]            point_x,
	input  logic signed [31:0]            point_y,
	input  logic                          last_point,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [psn_pkg::NW-1:0] normal_x,
	output logic signed [psn_pkg::NW-1:0] normal_y,
	output logic                          last_normal
);
	import psn_pkg::*;

	localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	logic               job_push, job_pop, job_avail;
	job_t               job_in, job_out;
	rel_t               rel;
	logic [IW:0]        rd_addr;
	logic signed [31:0] rd_x, rd_y;

	psn_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.last_point  (last_point),
		.job_push    (job_push),
		.job         (job_in),
		.rel         (rel),
		.rd_addr     (rd_addr),
		.rd_x        (rd_x),
		.rd_y        (rd_y)
	);

	psn_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.pop    (job_pop),
		.avail  (job_avail),
		.dout   (job_out)
	);

	psn_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_avail   (job_avail),
		.job         (job_out),
		.job_pop     (job_pop),
		.rd_addr     (rd_addr),
		.rd_x        (rd_x),
		.rd_y        (rd_y),
		.rel         (rel),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.normal_x    (normal_x),
		.normal_y    (normal_y),
		.last_normal (last_normal)
	);
endmodule
